// File: rtl/psu_pkg.sv
// Shared types, codes and controller/datapath interface of the particle swarm update block.
`timescale 1ns / 1ps

package psu_pkg;

  typedef logic signed [31:0] q16_t;

  // opcodes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_INERTIA   = 2'd0;
  localparam logic [1:0] CFG_COGNITIVE = 2'd1;
  localparam logic [1:0] CFG_SOCIAL    = 2'd2;

  // fixed-point constants (Q16.16)
  localparam logic signed [32:0] FIT_X_CENTER = 33'sd131072;
  localparam logic signed [32:0] FIT_Y_CENTER = 33'sd393216;

  typedef struct packed {
    logic        opcode;
    logic [4:0]  particle;
    q16_t        load_x;
    q16_t        load_y;
    logic [16:0] rand_cognitive;
    logic [16:0] rand_social;
  } in_req_t;

  typedef struct packed {
    logic [4:0]  particle_out;
    q16_t        pos_x;
    q16_t        pos_y;
    logic [19:0] fitness;
    logic        personal_improved;
    logic        global_improved;
    q16_t        global_best_x;
    q16_t        global_best_y;
    logic [19:0] global_best_fitness;
  } out_res_t;

  // one particle's stored state
  typedef struct packed {
    q16_t        pos_x;
    q16_t        pos_y;
    q16_t        vel_x;
    q16_t        vel_y;
    q16_t        pb_x;
    q16_t        pb_y;
    logic [19:0] pbf;
  } ent_t;

  // multiplier operand selection
  typedef enum logic [2:0] {
    MOP_NONE = 3'd0,
    MOP_RC1  = 3'd1,
    MOP_RC2  = 3'd2,
    MOP_WV   = 3'd3,
    MOP_COG  = 3'd4,
    MOP_SOC  = 3'd5,
    MOP_SQX  = 3'd6,
    MOP_SQY  = 3'd7
  } mop_t;

  typedef struct packed {
    logic accept;
    logic ld_pos;
    mop_t mop;
    logic coord;
    logic lat_rc1;
    logic lat_rc2;
    logic acc_first;
    logic acc_add;
    logic v_fin;
    logic x_fin;
    logic g_x;
    logic g_y;
    logic fit;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic ok;
    logic is_load;
  } sts_t;

endpackage

// File: rtl/particle_swarm_update.sv
// Top level of the particle swarm update block: controller plus datapath.
//
//  channel  direction  handshake           payload
//  in_      input      in_valid/in_stall   in_data   (in_req_t)
//  out_     output     out_valid/out_stall out_data  (out_res_t)
//  cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One request at a time through a single shared 34x34 multiplier.
// An update steps both coordinates through the multiplier; a load goes straight to the fitness;
// an update to a particle never loaded, or a particle index beyond the swarm, goes straight to the result.
// A finished result sits in the output register; the next request is taken
// while it waits, and the block holds in its last step if the slot is still full.
// Synchronous active-low reset clears control, loaded flags and the global best.
`timescale 1ns / 1ps

module particle_swarm_update
  import psu_pkg::*;
#(
  parameter int SWARM_SIZE        = 32,
  parameter int GAUSS_TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_req_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_res_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [17:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  psu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  psu_datapath #(
    .SWARM_SIZE        (SWARM_SIZE),
    .GAUSS_TABLE_DEPTH (GAUSS_TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

// File: rtl/psu_ctrl.sv
// Sequencer for the particle swarm update: steps the shared multiplier and the result slot.
`timescale 1ns / 1ps

module psu_ctrl
  import psu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [13:0] {
    ST_IDLE = 14'b00000000000001,
    ST_RD   = 14'b00000000000010,
    ST_RC1  = 14'b00000000000100,
    ST_RC2  = 14'b00000000001000,
    ST_WV   = 14'b00000000010000,
    ST_COG  = 14'b00000000100000,
    ST_SOC  = 14'b00000001000000,
    ST_VFIN = 14'b00000010000000,
    ST_XFIN = 14'b00000100000000,
    ST_SQX  = 14'b00001000000000,
    ST_SQY  = 14'b00010000000000,
    ST_GY   = 14'b00100000000000,
    ST_FIT  = 14'b01000000000000,
    ST_BEST = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   coord_r, coord_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    coord_nxt = coord_r;
    cmd       = '0;
    cmd.mop   = MOP_NONE;
    cmd.coord = coord_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) state_nxt = ST_RD;
      end
      ST_RD: begin
        coord_nxt = 1'b0;
        if (!sts.ok) begin
          state_nxt = ST_BEST;
        end else if (sts.is_load) begin
          cmd.ld_pos = 1'b1;
          state_nxt  = ST_SQX;
        end else begin
          // working position comes from the stored particle
          cmd.ld_pos = 1'b1;
          state_nxt  = ST_RC1;
        end
      end
      ST_RC1: begin
        cmd.mop   = MOP_RC1;
        state_nxt = ST_RC2;
      end
      ST_RC2: begin
        cmd.mop     = MOP_RC2;
        cmd.lat_rc1 = 1'b1;
        state_nxt   = ST_WV;
      end
      ST_WV: begin
        cmd.mop     = MOP_WV;
        cmd.lat_rc2 = !coord_r;
        state_nxt   = ST_COG;
      end
      ST_COG: begin
        cmd.mop       = MOP_COG;
        cmd.acc_first = 1'b1;
        state_nxt     = ST_SOC;
      end
      ST_SOC: begin
        cmd.mop     = MOP_SOC;
        cmd.acc_add = 1'b1;
        state_nxt   = ST_VFIN;
      end
      ST_VFIN: begin
        cmd.v_fin = 1'b1;
        state_nxt = ST_XFIN;
      end
      ST_XFIN: begin
        cmd.x_fin = 1'b1;
        if (!coord_r) begin
          coord_nxt = 1'b1;
          state_nxt = ST_WV;
        end else begin
          state_nxt = ST_SQX;
        end
      end
      ST_SQX: begin
        cmd.mop   = MOP_SQX;
        state_nxt = ST_SQY;
      end
      ST_SQY: begin
        cmd.mop   = MOP_SQY;
        cmd.g_x   = 1'b1;
        state_nxt = ST_GY;
      end
      ST_GY: begin
        cmd.g_y   = 1'b1;
        state_nxt = ST_FIT;
      end
      ST_FIT: begin
        cmd.fit   = 1'b1;
        state_nxt = ST_BEST;
      end
      ST_BEST: begin
        // wait for the result slot to free up
        cmd.commit = slot_free;
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result slot valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      coord_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      coord_r     <= coord_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/psu_datapath.sv
// Datapath: particle memory, shared multiplier, velocity/position update, fitness and bests.
`timescale 1ns / 1ps

module psu_datapath
  import psu_pkg::*;
#(
  parameter int SWARM_SIZE        = 32,
  parameter int GAUSS_TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  in_req_t     in_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [17:0] cfg_data,
  input  cmd_t        cmd,
  output sts_t        sts,
  output out_res_t    out_data
);

  localparam int AW = (SWARM_SIZE > 1) ? $clog2(SWARM_SIZE) : 1;
  localparam int GW = $clog2(GAUSS_TABLE_DEPTH);
  localparam logic [63:0] Q56_ONE = 64'd1 << 56;
  localparam logic signed [39:0] SAT_MAX = 40'sd2147483647;
  localparam logic signed [39:0] SAT_MIN = -40'sd2147483648;

  typedef logic [16:0] gtab_t [GAUSS_TABLE_DEPTH];

  // (a * b) >> 56, low 64 bits
  function automatic logic [63:0] mul_q56(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[119:56];
  endfunction

  // exp(-d^2) table over d^2 in [0,16), built at elaboration
  function automatic gtab_t build_gauss();
    gtab_t       t;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] v;
    logic [64:0] r;
    x    = 64'((64'd1 << 60) / GAUSS_TABLE_DEPTH);
    term = Q56_ONE;
    e    = Q56_ONE;
    v    = Q56_ONE;
    for (int k = 1; k <= 24; k++) begin
      term = mul_q56(term, x) / 64'(k);
      if (k[0]) e = e - term;
      else e = e + term;
    end
    for (int i = 0; i < GAUSS_TABLE_DEPTH; i++) begin
      r    = {1'b0, v} + (65'd1 << 39);
      t[i] = 17'(r >> 40);
      v    = mul_q56(v, e);
    end
    return t;
  endfunction

  localparam gtab_t GTAB = build_gauss();

  function automatic q16_t sat40(input logic signed [39:0] v);
    if (v > SAT_MAX) return q16_t'(SAT_MAX[31:0]);
    else if (v < SAT_MIN) return q16_t'(SAT_MIN[31:0]);
    else return v[31:0];
  endfunction

  // configuration registers
  logic [17:0] w_r, c1_r, c2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r  <= 18'd34669;
      c1_r <= 18'd80616;
      c2_r <= 18'd163476;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_INERTIA:   w_r  <= cfg_data;
        CFG_COGNITIVE: c1_r <= cfg_data;
        CFG_SOCIAL:    c2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // request capture and particle memory read
  in_req_t         req_r;
  logic            ok_r;
  ent_t            mem_r [SWARM_SIZE];
  ent_t            ent_rd_r;
  ent_t            ent_w;
  logic [SWARM_SIZE-1:0] loaded_r;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic            in_range;

  assign rd_addr  = AW'(in_data.particle);
  assign wr_addr  = AW'(req_r.particle);
  assign in_range = 32'(in_data.particle) < SWARM_SIZE;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r    <= in_data;
      ok_r     <= in_range && (in_data.opcode == OP_LOAD || loaded_r[rd_addr]);
      ent_rd_r <= mem_r[rd_addr];
    end
    if (cmd.commit && ok_r) mem_r[wr_addr] <= ent_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) loaded_r <= '0;
    else if (cmd.commit && ok_r) loaded_r[wr_addr] <= 1'b1;
  end

  assign sts.ok      = ok_r;
  assign sts.is_load = (req_r.opcode == OP_LOAD);

  // working registers
  q16_t pos_x_r, pos_y_r, vel_x_r, vel_y_r;
  q16_t gb_x_r, gb_y_r;
  logic [19:0] gbf_r;
  logic [18:0] rc1_r, rc2_r;
  logic signed [39:0] acc_r;
  logic signed [67:0] prod_r;
  logic [16:0] gx_r, gy_r;
  logic [19:0] fit_r;

  q16_t cur_x, cur_v, cur_pb, cur_gb, cur_vnew;
  logic signed [32:0] d_pb, d_gb, d_sqx, d_sqy;
  logic signed [33:0] op_a, op_b;
  logic signed [39:0] fs;

  assign cur_x    = cmd.coord ? pos_y_r : pos_x_r;
  assign cur_v    = cmd.coord ? ent_rd_r.vel_y : ent_rd_r.vel_x;
  assign cur_pb   = cmd.coord ? ent_rd_r.pb_y : ent_rd_r.pb_x;
  assign cur_gb   = cmd.coord ? gb_y_r : gb_x_r;
  assign cur_vnew = cmd.coord ? vel_y_r : vel_x_r;
  assign d_pb     = 33'(cur_pb) - 33'(cur_x);
  assign d_gb     = 33'(cur_gb) - 33'(cur_x);
  assign d_sqx    = 33'(pos_x_r) - FIT_X_CENTER;
  assign d_sqy    = 33'(pos_y_r) - FIT_Y_CENTER;
  assign fs       = $signed(prod_r[55:16]);

  // shared multiplier operands
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (cmd.mop)
      MOP_RC1: begin op_a = 34'(req_r.rand_cognitive); op_b = 34'(c1_r); end
      MOP_RC2: begin op_a = 34'(req_r.rand_social);    op_b = 34'(c2_r); end
      MOP_WV:  begin op_a = 34'(w_r);   op_b = 34'(cur_v); end
      MOP_COG: begin op_a = 34'(rc1_r); op_b = 34'(d_pb);  end
      MOP_SOC: begin op_a = 34'(rc2_r); op_b = 34'(d_gb);  end
      MOP_SQX: begin op_a = 34'(d_sqx); op_b = 34'(d_sqx); end
      MOP_SQY: begin op_a = 34'(d_sqy); op_b = 34'(d_sqy); end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  // gauss lookup from a registered square; zero at d^2 >= 16
  function automatic logic [16:0] gauss_of(input logic signed [67:0] sq);
    logic [31:0] idx;
    idx = (32'(sq[35:16]) * GAUSS_TABLE_DEPTH) >> 20;
    if (|sq[67:36]) return 17'd0;
    else return GTAB[GW'(idx)];
  endfunction

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    if (cmd.lat_rc1) rc1_r <= prod_r[34:16];
    if (cmd.lat_rc2) rc2_r <= prod_r[34:16];
    if (cmd.acc_first) acc_r <= fs;
    if (cmd.acc_add) acc_r <= acc_r + fs;
    // new velocity
    if (cmd.v_fin) begin
      if (cmd.coord) vel_y_r <= sat40(acc_r + fs);
      else vel_x_r <= sat40(acc_r + fs);
    end
    // new position
    if (cmd.x_fin) begin
      if (cmd.coord) pos_y_r <= sat40(40'(cur_x) + 40'(cur_vnew));
      else pos_x_r <= sat40(40'(cur_x) + 40'(cur_vnew));
    end
    // working position: load coordinates, or the stored particle for an update
    if (cmd.ld_pos) begin
      if (sts.is_load) begin
        pos_x_r <= req_r.load_x;
        pos_y_r <= req_r.load_y;
        vel_x_r <= '0;
        vel_y_r <= '0;
      end else begin
        pos_x_r <= ent_rd_r.pos_x;
        pos_y_r <= ent_rd_r.pos_y;
      end
    end
    if (cmd.g_x) gx_r <= gauss_of(prod_r);
    if (cmd.g_y) gy_r <= gauss_of(prod_r);
    if (cmd.fit) fit_r <= 20'(gx_r) * 20'd6 + 20'(gy_r) * 20'd3;
  end

  // best tracking and result
  logic pimp, gimp;
  q16_t gb_x_nxt, gb_y_nxt;
  logic [19:0] gbf_nxt;
  out_res_t res;
  out_res_t out_r;

  assign pimp = ok_r && (sts.is_load || fit_r > ent_rd_r.pbf);
  assign gimp = ok_r && (fit_r > gbf_r);
  assign gb_x_nxt = gimp ? pos_x_r : gb_x_r;
  assign gb_y_nxt = gimp ? pos_y_r : gb_y_r;
  assign gbf_nxt  = gimp ? fit_r : gbf_r;

  always_comb begin
    ent_w.pos_x = pos_x_r;
    ent_w.pos_y = pos_y_r;
    ent_w.vel_x = vel_x_r;
    ent_w.vel_y = vel_y_r;
    ent_w.pb_x  = pimp ? pos_x_r : ent_rd_r.pb_x;
    ent_w.pb_y  = pimp ? pos_y_r : ent_rd_r.pb_y;
    ent_w.pbf   = pimp ? fit_r : ent_rd_r.pbf;

    res.particle_out        = req_r.particle;
    res.pos_x               = ok_r ? pos_x_r : '0;
    res.pos_y               = ok_r ? pos_y_r : '0;
    res.fitness             = ok_r ? fit_r : '0;
    res.personal_improved   = pimp;
    res.global_improved     = gimp;
    res.global_best_x       = gb_x_nxt;
    res.global_best_y       = gb_y_nxt;
    res.global_best_fitness = gbf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gb_x_r <= '0;
      gb_y_r <= '0;
      gbf_r  <= '0;
    end else if (cmd.commit) begin
      gb_x_r <= gb_x_nxt;
      gb_y_r <= gb_y_nxt;
      gbf_r  <= gbf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) out_r <= res;
  end

  assign out_data = out_r;

endmodule

// File: rtl/psu_checker.sv
// Port-level checker for the particle swarm update block, bound to the top level.
`timescale 1ns / 1ps

module psu_port_checks
  import psu_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input out_res_t    out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one request at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one in flight");

  // a new global best equals this request's fitness
  a_gbest_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.global_improved |->
      out_data.global_best_fitness == out_data.fitness &&
      out_data.global_best_x == out_data.pos_x &&
      out_data.global_best_y == out_data.pos_y)
    else $error("global best does not match improving request");

  // fitness range
  a_fit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.fitness <= 20'd589824 &&
                  out_data.global_best_fitness <= 20'd589824)
    else $error("fitness out of range");

endmodule

bind particle_swarm_update psu_port_checks u_psu_port_checks (.*);
